### rtl/sha_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
`default_nettype none

package sha_pkg;

    // input function codes carried on tuser
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // block geometry
    localparam int BLOCK_BYTES = 64;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int ROUNDS      = 64;
    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int HASH_WORDS  = 8;
    localparam int WIDX_W      = $clog2(HASH_WORDS);

    localparam logic [FILL_W-1:0]  FILL_LAST   = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [FILL_W-1:0]  FILL_LENPOS = FILL_W'(BLOCK_BYTES - 8);
    localparam logic [ROUND_W-1:0] ROUND_LAST  = ROUND_W'(ROUNDS - 1);
    localparam logic [WIDX_W-1:0]  WIDX_LAST   = WIDX_W'(HASH_WORDS - 1);

    localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
    localparam logic [63:0] BLOCK_BITS    = 64'd512;

    // initial hash value
    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // round constants
    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // byte source for the block buffer write port
    typedef enum logic [1:0] {
        SRC_DATA = 2'd0,
        SRC_MARK = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } wr_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic              wr_en;
        wr_src_t           wr_src;
        logic              len_load;
        logic              round_start;
        logic              round_en;
        logic              h_update;
        logic              out_load;
        logic [WIDX_W-1:0] out_idx;
        logic              restart;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              round_last;
    } dp_sts_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

### rtl/sha_dp.sv
// sha-256 datapath: block buffer with message schedule window, round unit, hash state
`default_nettype none

module sha_dp
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [7:0]                 data_byte,
    input  wire sha_pkg::dp_cmd_t           cmd,
    output sha_pkg::dp_sts_t                sts,
    output logic [31:0]                     digest_word,
    output logic [sha_pkg::WIDX_W-1:0]      word_index
);
    import sha_pkg::*;

    // control state
    logic [FILL_W-1:0]  fill_reg,    fill_next;
    logic [ROUND_W-1:0] round_reg,   round_next;
    logic [63:0]        bit_len_reg, bit_len_next;
    logic [31:0]        hash_reg [HASH_WORDS];
    logic [31:0]        hash_next [HASH_WORDS];

    // payload state
    logic [31:0]        w_reg [16];
    logic [31:0]        w_next [16];
    logic [31:0]        v_reg [HASH_WORDS];
    logic [31:0]        v_next [HASH_WORDS];
    logic [63:0]        len_reg, len_next;
    logic [31:0]        digest_word_reg, digest_word_next;
    logic [WIDX_W-1:0]  word_index_reg, word_index_next;

    logic [7:0]         wr_byte;
    logic [31:0]        sched_word;
    logic [31:0]        t1;
    logic [31:0]        t2;

    // byte written into the block buffer
    always_comb
    begin
        unique case (cmd.wr_src)
            SRC_DATA: wr_byte = data_byte;
            SRC_MARK: wr_byte = PAD_MARK_BYTE;
            SRC_ZERO: wr_byte = 8'h00;
            SRC_LEN:  wr_byte = len_reg[63:56];
        endcase
    end

    // round arithmetic
    assign sched_word = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
              + K_TABLE[round_reg] + w_reg[0];
    assign t2 = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    // block buffer: byte writes while filling, schedule window shift while compressing
    always_comb
    begin
        w_next = w_reg;
        if (cmd.wr_en)
        begin
            w_next[fill_reg[FILL_W-1:2]][{~fill_reg[1:0], 3'b000} +: 8] = wr_byte;
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = sched_word;
        end
    end

    // working variables a..h
    always_comb
    begin
        v_next = v_reg;
        if (cmd.round_start)
        begin
            v_next = hash_reg;
        end
        else if (cmd.round_en)
        begin
            v_next[7] = v_reg[6];
            v_next[6] = v_reg[5];
            v_next[5] = v_reg[4];
            v_next[4] = v_reg[3] + t1;
            v_next[3] = v_reg[2];
            v_next[2] = v_reg[1];
            v_next[1] = v_reg[0];
            v_next[0] = t1 + t2;
        end
    end

    // hash words, bit length, fill and round counters
    always_comb
    begin
        hash_next    = hash_reg;
        bit_len_next = bit_len_reg;
        fill_next    = fill_reg;
        round_next   = round_reg;
        if (cmd.restart)
        begin
            hash_next    = H_INIT;
            bit_len_next = '0;
            fill_next    = '0;
        end
        else
        begin
            if (cmd.h_update)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
                bit_len_next = bit_len_reg + BLOCK_BITS;
            end
            if (cmd.wr_en)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        if (cmd.round_start)
        begin
            round_next = '0;
        end
        else if (cmd.round_en)
        begin
            round_next = round_reg + ROUND_W'(1);
        end
    end

    // length field captured at finish, shifted out msb first
    always_comb
    begin
        len_next = len_reg;
        if (cmd.len_load)
        begin
            len_next = bit_len_reg + {55'd0, fill_reg, 3'b000};
        end
        else if (cmd.wr_en && (cmd.wr_src == SRC_LEN))
        begin
            len_next = {len_reg[55:0], 8'h00};
        end
    end

    // digest output register
    always_comb
    begin
        digest_word_next = digest_word_reg;
        word_index_next  = word_index_reg;
        if (cmd.out_load)
        begin
            digest_word_next = hash_reg[cmd.out_idx];
            word_index_next  = cmd.out_idx;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            round_reg   <= '0;
            bit_len_reg <= '0;
            hash_reg    <= H_INIT;
        end
        else
        begin
            fill_reg    <= fill_next;
            round_reg   <= round_next;
            bit_len_reg <= bit_len_next;
            hash_reg    <= hash_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg           <= w_next;
        v_reg           <= v_next;
        len_reg         <= len_next;
        digest_word_reg <= digest_word_next;
        word_index_reg  <= word_index_next;
    end

    assign sts.fill       = fill_reg;
    assign sts.round_last = (round_reg == ROUND_LAST);
    assign digest_word    = digest_word_reg;
    assign word_index     = word_index_reg;

endmodule

`default_nettype wire

### rtl/sha_ctrl.sv
// sha-256 controller: request handshake, padding sequence, compression and digest emission
`default_nettype none

module sha_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire sha_pkg::dp_sts_t  sts,
    output sha_pkg::dp_cmd_t       cmd
);
    import sha_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MARK = 7'b0000010,
        ST_ZERO = 7'b0000100,
        ST_LEN  = 7'b0001000,
        ST_COMP = 7'b0010000,
        ST_UPD  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [WIDX_W-1:0] emit_idx_reg, emit_idx_next;
    logic              finishing_reg, finishing_next;
    logic              len_done_reg, len_done_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        emit_idx_next  = emit_idx_reg;
        finishing_next = finishing_reg;
        len_done_next  = len_done_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        cmd.out_idx    = emit_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == FUNC_ABSORB)
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = SRC_DATA;
                        if (sts.fill == FILL_LAST)
                        begin
                            cmd.round_start = 1'b1;
                            state_next      = ST_COMP;
                        end
                    end
                    else
                    begin
                        cmd.len_load   = 1'b1;
                        finishing_next = 1'b1;
                        len_done_next  = 1'b0;
                        state_next     = ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_MARK;
                if (sts.fill == FILL_LAST)
                begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_COMP;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (sts.fill == FILL_LENPOS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_src = SRC_ZERO;
                    if (sts.fill == FILL_LAST)
                    begin
                        cmd.round_start = 1'b1;
                        state_next      = ST_COMP;
                    end
                end
            end
            ST_LEN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = SRC_LEN;
                if (sts.fill == FILL_LAST)
                begin
                    cmd.round_start = 1'b1;
                    len_done_next   = 1'b1;
                    state_next      = ST_COMP;
                end
            end
            ST_COMP:
            begin
                cmd.round_en = 1'b1;
                if (sts.round_last)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.h_update = 1'b1;
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_done_reg)
                begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    emit_idx_next  = emit_idx_reg + WIDX_W'(1);
                    if (emit_idx_reg == WIDX_LAST)
                    begin
                        cmd.restart    = 1'b1;
                        finishing_next = 1'b0;
                        len_done_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            emit_idx_reg  <= '0;
            finishing_reg <= 1'b0;
            len_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_idx_reg  <= emit_idx_next;
            finishing_reg <= finishing_next;
            len_done_reg  <= len_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // buffer writes never overlap schedule shifts
    a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.round_en))
        else $error("buffer write during compression rounds");

    // a digest word is never loaded over one still waiting
    a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("digest word overwritten before it was taken");

    // compression only ever runs on a completely filled block
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP) |-> (sts.fill == '0))
        else $error("compression started on a partial block");

    // the final digest word returns the block to accepting requests
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && (emit_idx_reg == WIDX_LAST)) |=> (state_reg == ST_IDLE))
        else $error("block not idle after the last digest word");

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// sha-256 stream hasher top level: input and digest stream channels
//
// input channel (s_*): one request per byte. tuser = 0 absorbs the byte in tdata,
// tuser = 1 finishes the message (tdata ignored) and starts digest output.
// output channel (m_*): eight 32-bit digest words, most significant first, with
// the word position in tdata[34:32] and tlast on the eighth word.
// an absorb request writes its byte into the block buffer; the request that
// completes a 64-byte block then holds s_tready low through the 64 rounds of the
// single round unit and the hash update. a finish request walks the padding one
// buffer byte per cycle through the single write port, pausing while a block is
// compressed, with one idle step before the eight length bytes; when 56 or more
// bytes were pending, a second block is compressed. the padding is followed by
// one digest word per cycle while m_tready is high. after the eighth word is loaded
// the hash state, bit length and fill count return to their initial values and
// requests are taken again while that word still waits in the output register.
// a stalled receiver holds the pending digest word in the output register and
// pauses emission; reset returns the hash to its initial value and drops m_tvalid.
`default_nettype none

module sha256_stream_hasher
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
    output logic             m_tlast
);
    import sha_pkg::*;

    dp_cmd_t           cmd;
    dp_sts_t           sts;
    logic [31:0]       digest_word;
    logic [WIDX_W-1:0] word_index;

    // sequencing
    sha_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // buffer, rounds and hash state
    sha_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .digest_word (digest_word),
        .word_index  (word_index)
    );

    // output packing
    assign m_tdata = {5'b00000, word_index, digest_word};
    assign m_tlast = (word_index == WIDX_LAST);

endmodule

`default_nettype wire
